### hw/rtl/utf8d_pkg.sv
//------------------------------------------------------------------------------
// utf8d_pkg
// Shared types, constants and the lead byte classifier of the UTF-8 decoder.
//------------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

   localparam int unsigned CpWidth = 21;

   typedef logic [CpWidth-1:0] cp_type;

   // U+FFFD, given for stray or invalid lead bytes and for cut-short sequences.
   localparam cp_type ReplacementCp = 21'h00FFFD;

   // One decoded character as it leaves the block.
   typedef struct packed {
      cp_type code_point;
      logic   last_of_run;
   } result_type;

   // What a byte means when it is taken as the start of a character.
   typedef struct packed {
      logic       emit;
      cp_type     code_point;
      logic [1:0] remaining;
      cp_type     partial;
   } lead_type;

   // Everything one byte does: up to two results and the new decoder state.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
      logic [1:0] remaining;
      cp_type     partial;
   } step_type;

   function automatic lead_type lead_decode(input logic [7:0] b);
      lead_type lead;
      lead = '0;
      case (b) inside
         [8'h00:8'h7F]: begin
            lead.emit       = 1'b1;
            lead.code_point = cp_type'(b[6:0]);
         end
         [8'hC0:8'hDF]: begin
            lead.remaining = 2'd1;
            lead.partial   = cp_type'(b[4:0]);
         end
         [8'hE0:8'hEF]: begin
            lead.remaining = 2'd2;
            lead.partial   = cp_type'(b[3:0]);
         end
         [8'hF0:8'hF7]: begin
            lead.remaining = 2'd3;
            lead.partial   = cp_type'(b[2:0]);
         end
         default: begin
            // Stray continuation bytes and F8 to FF.
            lead.emit       = 1'b1;
            lead.code_point = ReplacementCp;
         end
      endcase
      return lead;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/utf8_stream_decoder.sv
//------------------------------------------------------------------------------
// utf8_stream_decoder
// Lenient UTF-8 decoder: one byte in per beat, decoded code points out.
//------------------------------------------------------------------------------
// The request channel carries one byte of text per beat; a zero byte ends a
// string and flushes any unfinished character as U+FFFD. The response channel
// carries one code point per beat, with last_of_run set on the final result
// caused by a given byte. A byte gives no, one or two results.
// Each accepted byte is decoded in the cycle it is accepted and its results
// are written into a two-entry output buffer, so the first result appears in
// the cycle after the byte's beat. The buffer takes a new byte whenever it
// will be empty at the end of the cycle, so the block runs at one byte per
// cycle while the receiver keeps up; a byte that gives two results holds off
// the next byte, since its second result must drain first.
// When the receiver stalls, the buffered results hold still and req_stall
// rises as soon as the buffer cannot be emptied in the current cycle.
// Synchronous reset empties the buffer and drops any partly decoded
// character; the block accepts bytes in the first cycle after reset.
//------------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder
   import utf8d_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [7:0]   req_in_byte,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [20:0]       rsp_code_point,
   output logic              rsp_last_of_run
);

   // Sequence state: continuation bytes still expected and the bits so far.
   logic [1:0] remaining_ff, remaining_in;
   cp_type     partial_ff, partial_in;

   // Output buffer: head entry is on the port, the tail holds a second result.
   logic [1:0] count_ff, count_in;
   result_type head_ff, head_in;
   result_type tail_ff, tail_in;

   step_type step;
   logic     accept;
   logic     pop;

   utf8d_decode u_decode (
      .in_byte   (req_in_byte),
      .remaining (remaining_ff),
      .partial   (partial_ff),
      .step      (step)
   );

   assign rsp_valid       = (count_ff != 2'd0);
   assign rsp_code_point  = head_ff.code_point;
   assign rsp_last_of_run = head_ff.last_of_run;

   assign pop = rsp_valid && !rsp_stall;

   // A byte may bring two results, so it is only taken when the buffer
   // drains completely in this cycle.
   assign req_stall = (count_ff == 2'd2) || ((count_ff == 2'd1) && rsp_stall);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      remaining_in = remaining_ff;
      partial_in   = partial_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      if (accept) begin
         remaining_in = step.remaining;
         partial_in   = step.partial;
         count_in     = step.count;
         head_in      = step.first;
         tail_in      = step.second;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         head_in  = tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= 2'd0;
         partial_ff   <= '0;
         count_ff     <= 2'd0;
      end else begin
         remaining_ff <= remaining_in;
         partial_ff   <= partial_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

`default_nettype wire

### hw/rtl/utf8d_decode.sv
//------------------------------------------------------------------------------
// utf8d_decode
// Combinational decode of one byte against the current sequence state.
//------------------------------------------------------------------------------
`default_nettype none

module utf8d_decode
   import utf8d_pkg::*;
(
   input  wire logic [7:0] in_byte,
   input  wire logic [1:0] remaining,
   input  wire cp_type     partial,
   output step_type        step
);

   lead_type lead;
   cp_type   merged;

   assign lead   = lead_decode(in_byte);
   assign merged = {partial[CpWidth-7:0], in_byte[5:0]};

   always_comb begin
      step           = '0;
      step.remaining = remaining;
      step.partial   = partial;
      if (remaining != 2'd0) begin
         if (in_byte[7:6] == 2'b10) begin
            step.remaining = remaining - 2'd1;
            step.partial   = merged;
            if (remaining == 2'd1) begin
               step.count = 2'd1;
               step.first = '{code_point: merged, last_of_run: 1'b1};
               step.partial = '0;
            end
         end else begin
            // The sequence is cut short; the same byte then starts afresh unless it is zero.
            step.remaining        = 2'd0;
            step.partial          = '0;
            step.first.code_point = ReplacementCp;
            if ((in_byte != 8'd0) && lead.emit) begin
               step.count             = 2'd2;
               step.first.last_of_run = 1'b0;
               step.second = '{code_point: lead.code_point, last_of_run: 1'b1};
            end else begin
               step.count             = 2'd1;
               step.first.last_of_run = 1'b1;
               if (in_byte != 8'd0) begin
                  step.remaining = lead.remaining;
                  step.partial   = lead.partial;
               end
            end
         end
      end else if (in_byte != 8'd0) begin
         step.remaining = lead.remaining;
         step.partial   = lead.partial;
         if (lead.emit) begin
            step.count = 2'd1;
            step.first = '{code_point: lead.code_point, last_of_run: 1'b1};
         end
      end
   end

endmodule

`default_nettype wire

### hw/rtl/utf8d_checker.sv
//------------------------------------------------------------------------------
// utf8d_checker
// Port-level assertions for the UTF-8 decoder, bound to its top level.
//------------------------------------------------------------------------------
`default_nettype none

module utf8d_checker
   import utf8d_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [7:0]  req_in_byte,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [20:0] rsp_code_point,
   input wire logic        rsp_last_of_run
);

   // A stalled request beat holds.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_in_byte))
      else $error("stalled request beat changed");

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code_point)
                                 && $stable(rsp_last_of_run))
      else $error("stalled response beat changed");

   // Only a cut-short sequence gives an earlier result, and that is U+FFFD.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> rsp_code_point == ReplacementCp)
      else $error("non-final result is not U+FFFD");

   // The second result of a pair follows straight after the first.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run && !rsp_stall |=> rsp_valid)
      else $error("second result of a pair missing");

   // No byte is taken while a pair is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> req_stall)
      else $error("byte accepted while a result pair is pending");

endmodule

bind utf8_stream_decoder utf8d_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_in_byte     (req_in_byte),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_code_point  (rsp_code_point),
   .rsp_last_of_run (rsp_last_of_run)
);

`default_nettype wire
